// ===== hw/rtl/ethpar_pkg.sv =====
// shared types and constants for the ethernet / ipv4 / tcp header parser
// no dependencies; used by every module of the block and by the checker
package ethpar_pkg;

    localparam int unsigned ETH_HEADER_BYTES = 14;
    localparam logic [15:0] MAX_FRAME_BYTES  = 16'hFFFF;
    localparam logic [15:0] COUNT_MAX        = 16'hFFFF;

    // header offsets from frame start; TCP_OFS_DOFF from the tcp header
    localparam logic [15:0] OFS_SRC_MAC   = 16'd6;
    localparam logic [15:0] OFS_ETYPE_HI  = 16'd12;
    localparam logic [15:0] OFS_ETYPE_LO  = 16'd13;
    localparam logic [15:0] OFS_IP_VHL    = 16'(ETH_HEADER_BYTES);
    localparam logic [15:0] OFS_IP_PROTO  = 16'(ETH_HEADER_BYTES + 9);
    localparam logic [15:0] OFS_IP_SRC    = 16'(ETH_HEADER_BYTES + 12);
    localparam logic [15:0] OFS_IP_DST    = 16'(ETH_HEADER_BYTES + 16);
    localparam logic [15:0] OFS_IP_END    = 16'(ETH_HEADER_BYTES + 20);
    localparam logic [15:0] TCP_OFS_DOFF  = 16'd12;
    localparam logic [5:0]  MIN_HDR_BYTES = 6'd20;
    localparam logic [3:0]  MIN_DOFF_WORDS = 4'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_ETHERTYPE = 2'd0;
    localparam logic [1:0] CFG_PROTOCOL  = 2'd1;
    localparam logic [1:0] CFG_PREVIEW   = 2'd2;

    localparam logic [15:0] RST_ETHERTYPE = 16'h0800;
    localparam logic [7:0]  RST_PROTOCOL  = 8'd6;
    localparam logic [7:0]  RST_PREVIEW   = 8'd16;

    localparam logic KIND_PREVIEW = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [2:0] {
        ST_VALID       = 3'd0,
        ST_NOT_IPV4    = 3'd1,
        ST_NOT_TCP     = 3'd2,
        ST_BAD_IP_LEN  = 3'd3,
        ST_BAD_TCP_LEN = 3'd4,
        ST_TRUNCATED   = 3'd5
    } status_t;

    typedef struct packed {
        logic [15:0] ethertype;
        logic [7:0]  protocol;
        logic [7:0]  preview;
    } cfg_t;

    typedef struct packed {
        logic        kind;
        status_t     status;
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [15:0] data_len;
        logic [7:0]  payload_byte;
        logic        last_result;
    } result_t;

    // up to two results per frame byte: a preview byte and/or a summary
    typedef struct packed {
        logic    first_valid;
        logic    second_valid;
        result_t first;
        result_t second;
    } push_t;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

    // m_tdata layout
    localparam int unsigned TDATA_W       = 224;
    localparam int unsigned STATUS_LSB    = 0;
    localparam int unsigned SRC_MAC_LSB   = 3;
    localparam int unsigned DST_MAC_LSB   = 51;
    localparam int unsigned SRC_IP_LSB    = 99;
    localparam int unsigned DST_IP_LSB    = 131;
    localparam int unsigned SRC_PORT_LSB  = 163;
    localparam int unsigned DST_PORT_LSB  = 179;
    localparam int unsigned PLEN_LSB      = 195;
    localparam int unsigned PBYTE_LSB     = 211;
    localparam int unsigned TDATA_USED    = 219;

endpackage

// ===== hw/rtl/ethpar_cfg_regs.sv =====
// configuration registers of the header parser: expected ethertype,
// expected ip protocol and payload preview count; depends on ethpar_pkg
module ethpar_cfg_regs
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_addr,
    input  logic [15:0]        cfg_wdata,
    output ethpar_pkg::cfg_t   cfg
);

    ethpar_pkg::cfg_t cfg_reg;
    ethpar_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                ethpar_pkg::CFG_ETHERTYPE: cfg_next.ethertype = cfg_wdata;
                ethpar_pkg::CFG_PROTOCOL:  cfg_next.protocol  = cfg_wdata[7:0];
                ethpar_pkg::CFG_PREVIEW:   cfg_next.preview   = cfg_wdata[7:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ethertype <= ethpar_pkg::RST_ETHERTYPE;
            cfg_reg.protocol  <= ethpar_pkg::RST_PROTOCOL;
            cfg_reg.preview   <= ethpar_pkg::RST_PREVIEW;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/ethpar_core.sv =====
// per-byte parse logic and frame state: header capture, checks, payload
// counting and result building; depends on ethpar_pkg
module ethpar_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic [7:0]         pkt_byte,
    input  logic               last,
    input  ethpar_pkg::cfg_t   cfg,
    output ethpar_pkg::push_t  push
);

    logic [15:0]          offset_reg,    offset_next;
    logic [5:0]           ip_hdr_reg,    ip_hdr_next;
    logic [5:0]           tcp_hdr_reg,   tcp_hdr_next;
    logic [47:0]          src_mac_reg,   src_mac_next;
    logic [47:0]          dst_mac_reg,   dst_mac_next;
    logic [31:0]          src_ip_reg,    src_ip_next;
    logic [31:0]          dst_ip_reg,    dst_ip_next;
    logic [15:0]          src_port_reg,  src_port_next;
    logic [15:0]          dst_port_reg,  dst_port_next;
    logic [15:0]          etype_reg,     etype_next;
    ethpar_pkg::status_t  status_reg,    status_next;
    logic [15:0]          count_reg,     count_next;

    logic [15:0]          tcp_start;
    logic [15:0]          hdr_end;
    logic                 preview;
    ethpar_pkg::status_t  sum_status;
    logic [15:0]          sum_len;
    ethpar_pkg::result_t  pv_res;
    ethpar_pkg::result_t  sm_res;

    always_comb
    begin
        offset_next   = offset_reg;
        ip_hdr_next   = ip_hdr_reg;
        tcp_hdr_next  = tcp_hdr_reg;
        src_mac_next  = src_mac_reg;
        dst_mac_next  = dst_mac_reg;
        src_ip_next   = src_ip_reg;
        dst_ip_next   = dst_ip_reg;
        src_port_next = src_port_reg;
        dst_port_next = dst_port_reg;
        etype_next    = etype_reg;
        status_next   = status_reg;
        count_next    = count_reg;
        preview       = 1'b0;
        tcp_start     = 16'(ethpar_pkg::ETH_HEADER_BYTES) + {10'd0, ip_hdr_reg};

        if (offset_reg != ethpar_pkg::MAX_FRAME_BYTES)
        begin
            if (status_reg == ethpar_pkg::ST_VALID)
            begin
                if (offset_reg < ethpar_pkg::OFS_SRC_MAC)
                begin
                    dst_mac_next = {dst_mac_reg[39:0], pkt_byte};
                end
                else if (offset_reg < ethpar_pkg::OFS_ETYPE_HI)
                begin
                    src_mac_next = {src_mac_reg[39:0], pkt_byte};
                end
                else if (offset_reg == ethpar_pkg::OFS_ETYPE_HI)
                begin
                    etype_next = {pkt_byte, 8'h00};
                end
                else if (offset_reg == ethpar_pkg::OFS_ETYPE_LO)
                begin
                    etype_next = {etype_reg[15:8], pkt_byte};
                    if ({etype_reg[15:8], pkt_byte} != cfg.ethertype)
                    begin
                        status_next = ethpar_pkg::ST_NOT_IPV4;
                    end
                end
                else if (offset_reg == ethpar_pkg::OFS_IP_VHL)
                begin
                    ip_hdr_next = {pkt_byte[3:0], 2'b00};
                end
                else if (offset_reg == ethpar_pkg::OFS_IP_PROTO)
                begin
                    if (pkt_byte != cfg.protocol)
                    begin
                        status_next = ethpar_pkg::ST_NOT_TCP;
                    end
                    else if (ip_hdr_reg < ethpar_pkg::MIN_HDR_BYTES)
                    begin
                        status_next = ethpar_pkg::ST_BAD_IP_LEN;
                    end
                end
                else if (offset_reg >= ethpar_pkg::OFS_IP_SRC &&
                         offset_reg <  ethpar_pkg::OFS_IP_DST)
                begin
                    src_ip_next = {src_ip_reg[23:0], pkt_byte};
                end
                else if (offset_reg >= ethpar_pkg::OFS_IP_DST &&
                         offset_reg <  ethpar_pkg::OFS_IP_END)
                begin
                    dst_ip_next = {dst_ip_reg[23:0], pkt_byte};
                end
                else if (offset_reg >= ethpar_pkg::OFS_IP_END)
                begin
                    if (offset_reg == tcp_start || offset_reg == tcp_start + 16'd1)
                    begin
                        src_port_next = {src_port_reg[7:0], pkt_byte};
                    end
                    else if (offset_reg == tcp_start + 16'd2 ||
                             offset_reg == tcp_start + 16'd3)
                    begin
                        dst_port_next = {dst_port_reg[7:0], pkt_byte};
                    end
                    else if (offset_reg == tcp_start + ethpar_pkg::TCP_OFS_DOFF &&
                             tcp_hdr_reg == 6'd0)
                    begin
                        if (pkt_byte[7:4] < ethpar_pkg::MIN_DOFF_WORDS)
                        begin
                            status_next = ethpar_pkg::ST_BAD_TCP_LEN;
                        end
                        else
                        begin
                            tcp_hdr_next = {pkt_byte[7:4], 2'b00};
                        end
                    end
                    else if (tcp_hdr_reg != 6'd0 &&
                             offset_reg >= tcp_start + {10'd0, tcp_hdr_reg})
                    begin
                        preview = (count_reg < {8'd0, cfg.preview});
                        if (count_reg != ethpar_pkg::COUNT_MAX)
                        begin
                            count_next = count_reg + 16'd1;
                        end
                    end
                end
            end
            offset_next = offset_reg + 16'd1;
        end

        // summary sees the state after this byte
        hdr_end    = 16'(ethpar_pkg::ETH_HEADER_BYTES) + {10'd0, ip_hdr_next} +
                     {10'd0, tcp_hdr_next};
        sum_status = status_next;
        sum_len    = 16'd0;
        if (status_next == ethpar_pkg::ST_VALID)
        begin
            if (tcp_hdr_next == 6'd0 || offset_next < hdr_end)
            begin
                sum_status = ethpar_pkg::ST_TRUNCATED;
            end
            else
            begin
                sum_len = count_next;
            end
        end

        pv_res.kind         = ethpar_pkg::KIND_PREVIEW;
        pv_res.status       = ethpar_pkg::ST_VALID;
        pv_res.src_mac      = src_mac_next;
        pv_res.dst_mac      = dst_mac_next;
        pv_res.src_ip       = src_ip_next;
        pv_res.dst_ip       = dst_ip_next;
        pv_res.src_port     = src_port_next;
        pv_res.dst_port     = dst_port_next;
        pv_res.data_len     = 16'd0;
        pv_res.payload_byte = pkt_byte;
        pv_res.last_result  = 1'b0;

        sm_res              = pv_res;
        sm_res.kind         = ethpar_pkg::KIND_SUMMARY;
        sm_res.status       = sum_status;
        sm_res.data_len     = sum_len;
        sm_res.payload_byte = 8'd0;
        sm_res.last_result  = 1'b1;

        push.first_valid  = en && (preview || last);
        push.second_valid = en && preview && last;
        push.first        = preview ? pv_res : sm_res;
        push.second       = sm_res;

        // end of frame: back to the reset state
        if (last)
        begin
            offset_next   = 16'd0;
            ip_hdr_next   = 6'd0;
            tcp_hdr_next  = 6'd0;
            src_mac_next  = 48'd0;
            dst_mac_next  = 48'd0;
            src_ip_next   = 32'd0;
            dst_ip_next   = 32'd0;
            src_port_next = 16'd0;
            dst_port_next = 16'd0;
            etype_next    = 16'd0;
            status_next   = ethpar_pkg::ST_VALID;
            count_next    = 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg   <= 16'd0;
            ip_hdr_reg   <= 6'd0;
            tcp_hdr_reg  <= 6'd0;
            src_mac_reg  <= 48'd0;
            dst_mac_reg  <= 48'd0;
            src_ip_reg   <= 32'd0;
            dst_ip_reg   <= 32'd0;
            src_port_reg <= 16'd0;
            dst_port_reg <= 16'd0;
            etype_reg    <= 16'd0;
            status_reg   <= ethpar_pkg::ST_VALID;
            count_reg    <= 16'd0;
        end
        else if (en)
        begin
            offset_reg   <= offset_next;
            ip_hdr_reg   <= ip_hdr_next;
            tcp_hdr_reg  <= tcp_hdr_next;
            src_mac_reg  <= src_mac_next;
            dst_mac_reg  <= dst_mac_next;
            src_ip_reg   <= src_ip_next;
            dst_ip_reg   <= dst_ip_next;
            src_port_reg <= src_port_next;
            dst_port_reg <= dst_port_next;
            etype_reg    <= etype_next;
            status_reg   <= status_next;
            count_reg    <= count_next;
        end
    end

endmodule

// ===== hw/rtl/ethpar_fifo.sv =====
// result queue: takes up to two results per cycle, hands out one per
// transfer; depends on ethpar_pkg
module ethpar_fifo
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ethpar_pkg::push_t    push,
    output logic                 room,
    output logic                 out_valid,
    input  logic                 out_pop,
    output ethpar_pkg::result_t  out_data
);

    localparam int unsigned AW = ethpar_pkg::FIFO_AW;

    ethpar_pkg::result_t mem [ethpar_pkg::FIFO_DEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg,  count_next;
    logic          pop;

    assign pop       = out_pop && (count_reg != '0);
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    // two free slots needed so a byte ending a frame can always land
    assign room      = (count_reg <= (AW+1)'(ethpar_pkg::FIFO_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + AW'(push.first_valid) + AW'(push.second_valid);
        rd_ptr_next = rd_ptr_reg + AW'(pop);
        count_next  = count_reg + (AW+1)'(push.first_valid) +
                      (AW+1)'(push.second_valid) - (AW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.first_valid)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.second_valid)
        begin
            mem[wr_ptr_reg + AW'(1)] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/ethernet_ipv4_tcp_header_parser.sv =====
// ethernet / ipv4 / tcp header parser.
// s side: one frame byte per transfer on s_tdata[7:0], s_tlast on the final
// byte of the frame. m side: results; m_tuser is the kind (0 payload preview
// byte, 1 end of frame summary), m_tlast marks the summary. a summary carries
// status, captured macs, ip addresses, ports and the payload length.
// cfg port: cfg_we writes cfg_wdata to register cfg_addr (0 ethertype,
// 1 protocol, 2 preview count); write only while no frame is in flight.
// a result reaches m through the input byte register and the result queue.
// throughput: one byte per cycle while the queue has room; the byte register
// feeds the parse logic, which pushes into a four-entry result queue. a byte
// that ends a frame inside the preview window gives two results, and the
// single m port drains them at one per cycle while m_tready is high.
// stall: when m_tready is low the queue fills, s_tready drops once fewer
// than two slots are free and a byte waits in the input register; the held
// result stays stable on m.
// reset: asynchronous, active low; registers go to their defaults
// (ethertype 0x0800, protocol 6, preview 16), frame state and queue clear.
// depends on ethpar_pkg, ethpar_cfg_regs, ethpar_core and ethpar_fifo
module ethernet_ipv4_tcp_header_parser
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // pkt_byte
    input  logic                              s_tlast,   // last
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status, src_mac, dst_mac, src_ip, dst_ip, src_port, dst_port,
    // payload length, payload_byte, zero fill
    output logic [ethpar_pkg::TDATA_W-1:0]    m_tdata,
    output logic                              m_tuser,   // kind
    output logic                              m_tlast,   // last_result
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_addr,
    input  logic [15:0]                       cfg_wdata
);

    ethpar_pkg::cfg_t    cfg;
    ethpar_pkg::push_t   push;
    ethpar_pkg::result_t res;

    logic       byte_vld_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       room;
    logic       process;

    assign process  = byte_vld_reg && room;
    assign s_tready = !byte_vld_reg || room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_vld_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            byte_vld_reg <= 1'b1;
        end
        else if (process)
        begin
            byte_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            byte_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

    ethpar_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ethpar_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (process),
        .pkt_byte (byte_reg),
        .last     (last_reg),
        .cfg      (cfg),
        .push     (push)
    );

    ethpar_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_pop   (m_tready),
        .out_data  (res)
    );

    assign m_tdata = {5'd0, res.payload_byte, res.data_len, res.dst_port,
                      res.src_port, res.dst_ip, res.src_ip, res.dst_mac,
                      res.src_mac, res.status};
    assign m_tuser = res.kind;
    assign m_tlast = res.last_result;

endmodule

// ===== hw/rtl/ethpar_checker.sv =====
// port-level checks for the header parser, bound to the top level
// depends on ethpar_pkg and ethernet_ipv4_tcp_header_parser
module ethpar_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [ethpar_pkg::TDATA_W-1:0]    m_tdata,
    input  logic                              m_tuser,
    input  logic                              m_tlast
);

    logic [2:0]  status;
    logic [15:0] plen;
    logic [7:0]  pbyte;

    assign status = m_tdata[ethpar_pkg::STATUS_LSB +: 3];
    assign plen   = m_tdata[ethpar_pkg::PLEN_LSB +: 16];
    assign pbyte  = m_tdata[ethpar_pkg::PBYTE_LSB +: 8];

    // the queue is cleared by the reset edge, so check at the following clock
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("result shown during reset");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_preview_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ethpar_pkg::KIND_PREVIEW |->
            !m_tlast && status == ethpar_pkg::ST_VALID && plen == 16'd0)
        else $error("malformed preview result");

    a_summary_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ethpar_pkg::KIND_SUMMARY |->
            m_tlast && pbyte == 8'd0)
        else $error("malformed summary result");

    a_error_no_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ethpar_pkg::KIND_SUMMARY &&
        status != ethpar_pkg::ST_VALID |-> plen == 16'd0)
        else $error("payload length on a failed frame");

endmodule

bind ethernet_ipv4_tcp_header_parser ethpar_checker u_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== tb/ethernet_ipv4_tcp_header_parser_tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for the ethernet / ipv4 / tcp header parser: feeds frames byte by byte,
// predicts preview and summary results in step with each transfer. depends on ethpar_pkg.
module ethernet_ipv4_tcp_header_parser_tb;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_byte_t;

    logic                             clk;
    logic                             rst_n     = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [7:0]                       s_tdata   = '0;  // pkt_byte
    logic                             s_tlast   = 1'b0; // last
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    // status, src_mac, dst_mac, src_ip, dst_ip, src_port, dst_port,
    // payload length, payload_byte, zero fill
    logic [ethpar_pkg::TDATA_W-1:0]   m_tdata;
    logic                             m_tuser;          // kind
    logic                             m_tlast;          // last_result
    logic                             cfg_we    = 1'b0;
    logic [1:0]                       cfg_addr  = '0;
    logic [15:0]                      cfg_wdata = '0;

    ethernet_ipv4_tcp_header_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    frame_byte_t             tx_bytes[$];
    ethpar_pkg::result_t     awaited_results[$];
    logic        steady = 1'b0;
    int          bytes_queued = 0;
    int          bytes_sent = 0;
    int          frames_seen = 0;
    int          results_checked = 0;
    int          error_count = 0;

    // register copies
    logic [15:0] want_etype;
    logic [7:0]  want_proto;
    logic [7:0]  preview_limit;

    // frame tracking state
    logic [15:0]         cur_ofs;
    logic [5:0]          ip_hlen;
    logic [5:0]          tcp_hlen;
    logic [47:0]         cap_src_mac;
    logic [47:0]         cap_dst_mac;
    logic [31:0]         cap_src_ip;
    logic [31:0]         cap_dst_ip;
    logic [15:0]         cap_src_port;
    logic [15:0]         cap_dst_port;
    logic [15:0]         cap_etype;
    ethpar_pkg::status_t frame_status;
    logic [15:0]         payload_cnt;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic clear_frame();
        cur_ofs      = '0;
        ip_hlen      = '0;
        tcp_hlen     = '0;
        cap_src_mac  = '0;
        cap_dst_mac  = '0;
        cap_src_ip   = '0;
        cap_dst_ip   = '0;
        cap_src_port = '0;
        cap_dst_port = '0;
        cap_etype    = '0;
        frame_status = ethpar_pkg::ST_VALID;
        payload_cnt  = '0;
    endtask

    function automatic ethpar_pkg::result_t snap_result(logic kind, ethpar_pkg::status_t st,
                                                        logic [15:0] plen, logic [7:0] pbyte,
                                                        logic lres);
        ethpar_pkg::result_t r;
        r.kind         = kind;
        r.status       = st;
        r.src_mac      = cap_src_mac;
        r.dst_mac      = cap_dst_mac;
        r.src_ip       = cap_src_ip;
        r.dst_ip       = cap_dst_ip;
        r.src_port     = cap_src_port;
        r.dst_port     = cap_dst_port;
        r.data_len     = plen;
        r.payload_byte = pbyte;
        r.last_result  = lres;
        return r;
    endfunction

    // advances the parse state by one accepted byte and queues what it produces
    task automatic parse_frame_byte(input logic [7:0] b, input logic lst);
        int                  ofs;
        int                  tcp_start;
        int                  hdr_end;
        ethpar_pkg::status_t st;
        logic [15:0]         plen;
        ofs       = cur_ofs;
        tcp_start = ethpar_pkg::ETH_HEADER_BYTES + ip_hlen;
        if (ofs < ethpar_pkg::MAX_FRAME_BYTES)
        begin
            if (frame_status == ethpar_pkg::ST_VALID)
            begin
                if (ofs < 6)
                    cap_dst_mac = {cap_dst_mac[39:0], b};
                else if (ofs < 12)
                    cap_src_mac = {cap_src_mac[39:0], b};
                else if (ofs == 12)
                    cap_etype = {b, 8'h00};
                else if (ofs == 13)
                begin
                    cap_etype = {cap_etype[15:8], b};
                    if (cap_etype != want_etype)
                        frame_status = ethpar_pkg::ST_NOT_IPV4;
                end
                else if (ofs == ethpar_pkg::ETH_HEADER_BYTES)
                    ip_hlen = {b[3:0], 2'b00};
                else if (ofs == ethpar_pkg::ETH_HEADER_BYTES + 9)
                begin
                    if (b != want_proto)
                        frame_status = ethpar_pkg::ST_NOT_TCP;
                    else if (ip_hlen < 20)
                        frame_status = ethpar_pkg::ST_BAD_IP_LEN;
                end
                else if (ofs >= ethpar_pkg::ETH_HEADER_BYTES + 12 &&
                         ofs < ethpar_pkg::ETH_HEADER_BYTES + 16)
                    cap_src_ip = {cap_src_ip[23:0], b};
                else if (ofs >= ethpar_pkg::ETH_HEADER_BYTES + 16 &&
                         ofs < ethpar_pkg::ETH_HEADER_BYTES + 20)
                    cap_dst_ip = {cap_dst_ip[23:0], b};
                else if (ofs >= ethpar_pkg::ETH_HEADER_BYTES + 20)
                begin
                    if (ofs == tcp_start || ofs == tcp_start + 1)
                        cap_src_port = {cap_src_port[7:0], b};
                    else if (ofs == tcp_start + 2 || ofs == tcp_start + 3)
                        cap_dst_port = {cap_dst_port[7:0], b};
                    else if (ofs == tcp_start + 12 && tcp_hlen == 0)
                    begin
                        if (b[7:4] < 4'd5)
                            frame_status = ethpar_pkg::ST_BAD_TCP_LEN;
                        else
                            tcp_hlen = {b[7:4], 2'b00};
                    end
                    else if (tcp_hlen != 0 && ofs >= tcp_start + tcp_hlen)
                    begin
                        if (payload_cnt < preview_limit)
                            awaited_results.push_back(
                                snap_result(ethpar_pkg::KIND_PREVIEW, ethpar_pkg::ST_VALID,
                                            16'd0, b, 1'b0));
                        if (payload_cnt != ethpar_pkg::COUNT_MAX)
                            payload_cnt++;
                    end
                end
            end
            cur_ofs = cur_ofs + 16'd1;
        end
        if (lst)
        begin
            st   = frame_status;
            plen = '0;
            if (st == ethpar_pkg::ST_VALID)
            begin
                hdr_end = ethpar_pkg::ETH_HEADER_BYTES + ip_hlen + tcp_hlen;
                if (tcp_hlen == 0 || cur_ofs < hdr_end)
                    st = ethpar_pkg::ST_TRUNCATED;
                else
                    plen = payload_cnt;
            end
            awaited_results.push_back(snap_result(ethpar_pkg::KIND_SUMMARY, st, plen, 8'h00,
                                                  1'b1));
            frames_seen++;
            clear_frame();
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        frame_byte_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                parse_frame_byte(s_tdata, s_tlast);
                bytes_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (tx_bytes.size() != 0 && (steady || $urandom_range(0, 99) >= 16))
                begin
                    nxt = tx_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.data;
                    s_tlast  <= nxt.last;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] seen);
        if (want !== seen)
        begin
            error_count++;
            if (error_count <= 10)
                $display("mismatch on %s at %0t: expected %0h, got %0h", name, $realtime, want,
                         seen);
        end
    endtask

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin : watch_proc
        ethpar_pkg::result_t exp_r;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_checked++;
                if (awaited_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected result at %0t: kind %0b status %0d", $realtime,
                                 m_tuser, m_tdata[ethpar_pkg::STATUS_LSB +: 3]);
                end
                else
                begin
                    exp_r = awaited_results.pop_front();
                    check_field("kind", exp_r.kind, m_tuser);
                    check_field("status", exp_r.status,
                                m_tdata[ethpar_pkg::STATUS_LSB +: 3]);
                    check_field("src_mac", exp_r.src_mac,
                                m_tdata[ethpar_pkg::SRC_MAC_LSB +: 48]);
                    check_field("dst_mac", exp_r.dst_mac,
                                m_tdata[ethpar_pkg::DST_MAC_LSB +: 48]);
                    check_field("src_ip", exp_r.src_ip,
                                m_tdata[ethpar_pkg::SRC_IP_LSB +: 32]);
                    check_field("dst_ip", exp_r.dst_ip,
                                m_tdata[ethpar_pkg::DST_IP_LSB +: 32]);
                    check_field("src_port", exp_r.src_port,
                                m_tdata[ethpar_pkg::SRC_PORT_LSB +: 16]);
                    check_field("dst_port", exp_r.dst_port,
                                m_tdata[ethpar_pkg::DST_PORT_LSB +: 16]);
                    check_field("data_len", exp_r.data_len,
                                m_tdata[ethpar_pkg::PLEN_LSB +: 16]);
                    check_field("payload_byte", exp_r.payload_byte,
                                m_tdata[ethpar_pkg::PBYTE_LSB +: 8]);
                    check_field("last_result", exp_r.last_result, m_tlast);
                end
            end
            m_tready <= steady || ($urandom_range(0, 99) >= 16);
        end
    end

    task automatic push_byte(input logic [7:0] d, input logic l);
        frame_byte_t fb;
        fb.data = d;
        fb.last = l;
        tx_bytes.push_back(fb);
        bytes_queued++;
    endtask

    // fill 0 random, 1 zeros, 2 ones for the bytes the parser does not check
    function automatic logic [7:0] pick_byte(input int fill);
        if (fill == 1)
            return 8'h00;
        if (fill == 2)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // cut > 0 keeps only the first cut bytes of the frame
    task automatic queue_frame(input logic [15:0] etype, input logic [7:0] proto,
                               input logic [3:0] ihl, input logic [3:0] doff,
                               input int plen, input int cut, input int fill);
        logic [7:0] fr[$];
        logic [7:0] b;
        int         ip_len;
        int         tcp_len;
        int         n;
        ip_len  = (ihl < 5) ? 20 : 4 * int'(ihl);
        tcp_len = (doff < 5) ? 20 : 4 * int'(doff);
        for (int i = 0; i < 12; i++)
            fr.push_back(pick_byte(fill));
        fr.push_back(etype[15:8]);
        fr.push_back(etype[7:0]);
        b = pick_byte(fill);
        fr.push_back({b[7:4], ihl});
        for (int i = 0; i < 8; i++)
            fr.push_back(pick_byte(fill));
        fr.push_back(proto);
        for (int i = 0; i < ip_len - 10; i++)
            fr.push_back(pick_byte(fill));
        for (int i = 0; i < 12; i++)
            fr.push_back(pick_byte(fill));
        b = pick_byte(fill);
        fr.push_back({doff, b[3:0]});
        for (int i = 0; i < tcp_len - 13 + plen; i++)
            fr.push_back(pick_byte(fill));
        n = (cut > 0 && cut < fr.size()) ? cut : fr.size();
        for (int i = 0; i < n; i++)
            push_byte(fr[i], i == n - 1);
    endtask

    // mostly well-formed frames with random content, the rest broken or noise
    task automatic queue_random_frame(input int max_plen);
        int          sel;
        int          plen;
        int          cut;
        int          n;
        logic [15:0] et;
        logic [7:0]  pr;
        logic [3:0]  ihl;
        logic [3:0]  doff;
        sel  = $urandom_range(0, 99);
        et   = want_etype;
        pr   = want_proto;
        ihl  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
        doff = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
        plen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, max_plen)
                                           : $urandom_range(0, 24);
        cut  = 0;
        if (sel >= 98)
        begin
            n = $urandom_range(1, 40);
            for (int i = 0; i < n; i++)
                push_byte(8'($urandom_range(0, 255)), i == n - 1);
        end
        else
        begin
            if (sel >= 70 && sel < 78)
                et = want_etype ^ 16'($urandom_range(1, 65535));
            else if (sel >= 78 && sel < 84)
                pr = want_proto ^ 8'($urandom_range(1, 255));
            else if (sel >= 84 && sel < 88)
                ihl = 4'($urandom_range(0, 4));
            else if (sel >= 88 && sel < 92)
                doff = 4'($urandom_range(0, 4));
            else if (sel >= 92)
                cut = $urandom_range(1, 13 + 4 * int'(ihl) + 4 * int'(doff));
            queue_frame(et, pr, ihl, doff, plen, cut, 0);
        end
    endtask

    task automatic run_random(input int budget, input int max_plen);
        int start;
        start = bytes_queued;
        while (bytes_queued - start < budget)
            queue_random_frame(max_plen);
    endtask

    // returns once every queued byte went through and every result came back
    task automatic wait_drained();
        while (tx_bytes.size() != 0 || s_tvalid || awaited_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic apply_settings(input logic [15:0] etype, input logic [7:0] proto,
                                  input logic [7:0] prev);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= ethpar_pkg::CFG_ETHERTYPE;
        cfg_wdata <= etype;
        @(posedge clk);
        cfg_addr  <= ethpar_pkg::CFG_PROTOCOL;
        cfg_wdata <= {8'h00, proto};
        @(posedge clk);
        cfg_addr  <= ethpar_pkg::CFG_PREVIEW;
        cfg_wdata <= {8'h00, prev};
        @(posedge clk);
        cfg_we    <= 1'b0;
        want_etype    = etype;
        want_proto    = proto;
        preview_limit = prev;
        @(negedge clk);
    endtask

    initial
    begin
        want_etype    = ethpar_pkg::RST_ETHERTYPE;
        want_proto    = ethpar_pkg::RST_PROTOCOL;
        preview_limit = ethpar_pkg::RST_PREVIEW;
        clear_frame();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed frames on the reset register values
        queue_frame(16'h0800, 8'd6, 4'd5, 4'd5, 20, 0, 0);      // preview stops at 16
        queue_frame(16'h0800, 8'd6, 4'd5, 4'd5, 0, 0, 2);       // no payload, ones
        queue_frame(16'h0800, 8'd6, 4'd5, 4'd5, 3, 0, 1);       // last byte previewed, zeros
        queue_frame(16'h0800, 8'd6, 4'd15, 4'd15, 5, 0, 0);     // longest headers
        queue_frame(16'h0806, 8'd6, 4'd5, 4'd5, 4, 0, 0);       // not ipv4
        queue_frame(16'h86DD, 8'd17, 4'd5, 4'd5, 4, 0, 0);      // ethertype checked first
        queue_frame(16'h0800, 8'd17, 4'd5, 4'd5, 4, 0, 0);      // not tcp
        queue_frame(16'h0800, 8'd6, 4'd4, 4'd5, 4, 0, 0);       // short ip header
        queue_frame(16'h0800, 8'd17, 4'd0, 4'd5, 4, 0, 0);      // protocol before ip length
        queue_frame(16'h0800, 8'd6, 4'd5, 4'd4, 4, 0, 0);       // short tcp header
        queue_frame(16'h0800, 8'd6, 4'd5, 4'd0, 4, 0, 2);
        queue_frame(16'h0800, 8'd6, 4'd5, 4'd5, 4, 1, 0);       // single byte frame
        queue_frame(16'h0800, 8'd6, 4'd5, 4'd5, 4, 10, 0);      // ends inside the macs
        queue_frame(16'h0800, 8'd6, 4'd5, 4'd5, 4, 40, 0);      // ends before data offset
        queue_frame(16'h0800, 8'd6, 4'd5, 4'd15, 4, 70, 0);     // ends inside tcp options
        queue_frame(16'h0800, 8'd6, 4'd6, 4'd8, 0, 0, 0);       // ends right at header end
        wait_drained();

        apply_settings(16'h0000, 8'h00, 8'h00);
        run_random(70, 40);
        wait_drained();

        apply_settings(16'hFFFF, 8'hFF, 8'hFF);
        queue_frame(16'hFFFF, 8'hFF, 4'd5, 4'd5, 100, 0, 0);
        run_random(70, 80);
        wait_drained();

        // back-to-back transfers on both sides
        steady = 1'b1;
        apply_settings(16'h86DD, 8'd17, 8'd1);
        run_random(150, 40);
        wait_drained();
        steady = 1'b0;

        apply_settings(16'h0800, 8'd6, 8'($urandom_range(2, 40)));
        run_random(70, 60);
        wait_drained();
        run_random(70, 60);
        wait_drained();
        repeat (20) @(posedge clk);

        $display("sent %0d bytes in %0d frames, checked %0d results, five register sets",
                 bytes_sent, frames_seen, results_checked);
        $display("covered every status, register extremes and back-to-back traffic");
        if (error_count == 0 && awaited_results.size() == 0)
            $display("PASS ethernet_ipv4_tcp_header_parser");
        else
            $display("FAIL ethernet_ipv4_tcp_header_parser");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("timeout with %0d results outstanding", awaited_results.size());
        $display("FAIL ethernet_ipv4_tcp_header_parser");
        $finish;
    end

endmodule
